// ----- sv/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types, step codes and the control store of the ellipse rasterizer
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

	// Datapath actions, one per control word
	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_LOAD      = 4'd1,
		OP_SET_ASQ   = 4'd2,
		OP_SET_BSQ   = 4'd3,
		OP_INIT      = 4'd4,
		OP_R1_XY     = 4'd5,
		OP_R1_DEC    = 4'd6,
		OP_SET_DONE  = 4'd7,
		OP_TMP_XX    = 4'd8,
		OP_TMP_YY    = 4'd9,
		OP_ACC       = 4'd10,
		OP_R2_INIT   = 4'd11,
		OP_R2_XY     = 4'd12,
		OP_R2_DEC    = 4'd13,
		OP_EMIT      = 4'd14,
		OP_EMIT_ZERO = 4'd15
	} op_t;

	// Multiplier operand pairs
	typedef enum logic [2:0] {
		M_NONE  = 3'd0,
		M_AA    = 3'd1,
		M_BB    = 3'd2,
		M_ASQ_B = 3'd3,
		M_XX    = 3'd4,
		M_YY    = 3'd5,
		M_BSQ_T = 3'd6,
		M_ASQ_T = 3'd7
	} mul_t;

	// Branch conditions
	typedef enum logic [1:0] {
		C_ALWAYS   = 2'd0,
		C_KEEP_R1  = 2'd1,
		C_Y_ZERO   = 2'd2,
		C_OUT_BUSY = 2'd3
	} cond_t;

	typedef enum logic {
		J_BRANCH   = 1'b0,
		J_DISPATCH = 1'b1
	} jump_t;

	// Drawing phase, one-hot
	typedef enum logic [2:0] {
		PH_DONE = 3'b001,
		PH_ONE  = 3'b010,
		PH_TWO  = 3'b100
	} phase_t;

	typedef logic [4:0] step_t;

	localparam step_t S_IDLE    = 5'd0;
	localparam step_t S_ST_AA   = 5'd1;
	localparam step_t S_ST_BB   = 5'd2;
	localparam step_t S_ST_AB   = 5'd3;
	localparam step_t S_ST_INIT = 5'd4;
	localparam step_t S_SETTLE  = 5'd5;
	localparam step_t S_R1A     = 5'd6;
	localparam step_t S_R1B     = 5'd7;
	localparam step_t S_SET_CHK = 5'd8;
	localparam step_t S_R2_XX   = 5'd9;
	localparam step_t S_R2_YY   = 5'd10;
	localparam step_t S_R2_BT   = 5'd11;
	localparam step_t S_R2_AT   = 5'd12;
	localparam step_t S_R2_INIT = 5'd13;
	localparam step_t S_FIN     = 5'd14;
	localparam step_t S_R2A     = 5'd15;
	localparam step_t S_R2B     = 5'd16;
	localparam step_t S_EMIT    = 5'd17;
	localparam step_t S_ZEMIT   = 5'd18;

	typedef struct packed {
		op_t   op;
		mul_t  mul;
		cond_t cond;
		jump_t jump;
		step_t tgt_t;
		step_t tgt_f;
	} ctrl_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic keep_r1;
		logic y_zero;
		logic ph_one;
		logic ph_two;
	} stat_t;

	function automatic ctrl_t mer_cw(input op_t op, input mul_t mul, input cond_t cond,
			input jump_t jump, input step_t tgt_t, input step_t tgt_f);
		ctrl_t cw;
		cw.op    = op;
		cw.mul   = mul;
		cw.cond  = cond;
		cw.jump  = jump;
		cw.tgt_t = tgt_t;
		cw.tgt_f = tgt_f;
		return cw;
	endfunction

	// Control store: one word per step
	function automatic ctrl_t mer_ucode(input step_t pc);
		ctrl_t cw;
		case (pc)
			S_IDLE:    cw = mer_cw(OP_LOAD, M_NONE, C_ALWAYS, J_DISPATCH, S_IDLE, S_IDLE);
			S_ST_AA:   cw = mer_cw(OP_NONE, M_AA, C_ALWAYS, J_BRANCH, S_ST_BB, S_ST_BB);
			S_ST_BB:   cw = mer_cw(OP_SET_ASQ, M_BB, C_ALWAYS, J_BRANCH, S_ST_AB, S_ST_AB);
			S_ST_AB:   cw = mer_cw(OP_SET_BSQ, M_ASQ_B, C_ALWAYS, J_BRANCH,
					S_ST_INIT, S_ST_INIT);
			S_ST_INIT: cw = mer_cw(OP_INIT, M_NONE, C_ALWAYS, J_BRANCH, S_SETTLE, S_SETTLE);
			S_SETTLE:  cw = mer_cw(OP_NONE, M_NONE, C_KEEP_R1, J_BRANCH, S_EMIT, S_SET_CHK);
			S_R1A:     cw = mer_cw(OP_R1_XY, M_NONE, C_ALWAYS, J_BRANCH, S_R1B, S_R1B);
			S_R1B:     cw = mer_cw(OP_R1_DEC, M_NONE, C_KEEP_R1, J_BRANCH, S_EMIT, S_SET_CHK);
			S_SET_CHK: cw = mer_cw(OP_NONE, M_NONE, C_Y_ZERO, J_BRANCH, S_FIN, S_R2_XX);
			S_R2_XX:   cw = mer_cw(OP_NONE, M_XX, C_ALWAYS, J_BRANCH, S_R2_YY, S_R2_YY);
			S_R2_YY:   cw = mer_cw(OP_TMP_XX, M_YY, C_ALWAYS, J_BRANCH, S_R2_BT, S_R2_BT);
			S_R2_BT:   cw = mer_cw(OP_TMP_YY, M_BSQ_T, C_ALWAYS, J_BRANCH, S_R2_AT, S_R2_AT);
			S_R2_AT:   cw = mer_cw(OP_ACC, M_ASQ_T, C_ALWAYS, J_BRANCH, S_R2_INIT, S_R2_INIT);
			S_R2_INIT: cw = mer_cw(OP_R2_INIT, M_NONE, C_ALWAYS, J_BRANCH, S_EMIT, S_EMIT);
			S_FIN:     cw = mer_cw(OP_SET_DONE, M_NONE, C_ALWAYS, J_BRANCH, S_EMIT, S_EMIT);
			S_R2A:     cw = mer_cw(OP_R2_XY, M_NONE, C_ALWAYS, J_BRANCH, S_R2B, S_R2B);
			S_R2B:     cw = mer_cw(OP_R2_DEC, M_NONE, C_ALWAYS, J_BRANCH, S_EMIT, S_EMIT);
			S_EMIT:    cw = mer_cw(OP_EMIT, M_NONE, C_OUT_BUSY, J_BRANCH, S_EMIT, S_IDLE);
			S_ZEMIT:   cw = mer_cw(OP_EMIT_ZERO, M_NONE, C_OUT_BUSY, J_BRANCH,
					S_ZEMIT, S_IDLE);
			default:   cw = mer_cw(OP_NONE, M_NONE, C_ALWAYS, J_BRANCH, S_IDLE, S_IDLE);
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

// ----- sv/mer_seq.sv -----
// ----------------------------------------------------------------------------
// mer_seq
// Step counter and control store readout with conditional branches and the
// item dispatch taken in the idle step.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           func,
	input  logic           out_busy,
	input  mer_pkg::stat_t stat,
	output mer_pkg::ctrl_t ctrl,
	output logic           idle
);
	import mer_pkg::*;

	step_t pc_q;
	step_t pc_next;
	logic  cond_hit;

	// Read the control word of the current step
	always_comb begin
		ctrl = mer_ucode(pc_q);
	end

	assign idle = (pc_q == S_IDLE);

	// Evaluate the branch condition
	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:   cond_hit = 1'b1;
			C_KEEP_R1:  cond_hit = stat.keep_r1;
			C_Y_ZERO:   cond_hit = stat.y_zero;
			C_OUT_BUSY: cond_hit = out_busy;
			default:    cond_hit = 1'b1;
		endcase
	end

	// Pick the next step
	always_comb begin
		if (ctrl.jump == J_DISPATCH) begin
			if (!accept) begin
				pc_next = S_IDLE;
			end else if (!func) begin
				pc_next = S_ST_AA;
			end else if (stat.ph_one) begin
				pc_next = S_R1A;
			end else if (stat.ph_two) begin
				pc_next = S_R2A;
			end else begin
				pc_next = S_ZEMIT;
			end
		end else begin
			pc_next = cond_hit ? ctrl.tgt_t : ctrl.tgt_f;
		end
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

`default_nettype wire

// ----- sv/mer_dpath.sv -----
// ----------------------------------------------------------------------------
// mer_dpath
// Ellipse datapath: geometry registers, decision and step terms, one shared
// registered multiplier, driven by the sequencer control word.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_dpath #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mer_pkg::ctrl_t               ctrl,
	input  logic                         load,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-2:0]        radius_x,
	input  logic [COORD_BITS-2:0]        radius_y,
	input  logic [23:0]                  color,
	output mer_pkg::stat_t               stat,
	output logic signed [COORD_BITS+1:0] pt_right_x,
	output logic signed [COORD_BITS+1:0] pt_left_x,
	output logic signed [COORD_BITS+1:0] pt_lower_y,
	output logic signed [COORD_BITS+1:0] pt_upper_y,
	output logic [23:0]                  pt_color,
	output logic                         pt_last
);
	import mer_pkg::*;

	localparam int RAD = COORD_BITS - 1;
	localparam int SQ  = 2 * RAD;
	localparam int MW  = 2 * RAD + 2;
	localparam int DW  = 2 * MW;
	localparam int ST  = 3 * RAD + 2;

	logic [COORD_BITS-1:0] ctr_x_q, ctr_y_q;
	logic [RAD-1:0]        a_q, b_q;
	logic [SQ-1:0]         asq_q, bsq_q;
	logic [RAD-1:0]        cur_x_q, cur_y_q;
	logic signed [DW-1:0]  dec_q;
	logic [ST-1:0]         sx_q, sy_q;
	logic signed [MW-1:0]  tmp_q;
	logic signed [DW-1:0]  acc_q;
	logic [23:0]           color_q;
	logic                  dneg_q, dpos_q;
	phase_t                phase_q;

	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [DW-1:0]  prod_s1;

	logic [RAD-1:0]        ym;
	logic [ST-1:0]         two_bsq, two_asq;
	logic signed [DW-1:0]  asq_w, bsq_w, sx_w, sy_w;
	logic signed [DW-1:0]  r2_base;

	assign ym      = cur_y_q - 1'b1;
	assign two_bsq = {{(ST-SQ-1){1'b0}}, bsq_q, 1'b0};
	assign two_asq = {{(ST-SQ-1){1'b0}}, asq_q, 1'b0};
	assign asq_w   = $signed({{(DW-SQ){1'b0}}, asq_q});
	assign bsq_w   = $signed({{(DW-SQ){1'b0}}, bsq_q});
	assign sx_w    = $signed({{(DW-ST){1'b0}}, sx_q});
	assign sy_w    = $signed({{(DW-ST){1'b0}}, sy_q});

	// Select multiplier operands
	always_comb begin
		case (ctrl.mul)
			M_AA: begin
				mul_a = $signed({{(MW-RAD){1'b0}}, a_q});
				mul_b = $signed({{(MW-RAD){1'b0}}, a_q});
			end
			M_BB: begin
				mul_a = $signed({{(MW-RAD){1'b0}}, b_q});
				mul_b = $signed({{(MW-RAD){1'b0}}, b_q});
			end
			M_ASQ_B: begin
				mul_a = $signed({{(MW-SQ){1'b0}}, asq_q});
				mul_b = $signed({{(MW-RAD){1'b0}}, b_q});
			end
			M_XX: begin
				mul_a = $signed({{(MW-RAD){1'b0}}, cur_x_q});
				mul_b = $signed({{(MW-RAD){1'b0}}, cur_x_q});
			end
			M_YY: begin
				mul_a = $signed({{(MW-RAD){1'b0}}, ym});
				mul_b = $signed({{(MW-RAD){1'b0}}, ym});
			end
			M_BSQ_T: begin
				mul_a = $signed({{(MW-SQ){1'b0}}, bsq_q});
				mul_b = tmp_q;
			end
			M_ASQ_T: begin
				mul_a = $signed({{(MW-SQ){1'b0}}, asq_q});
				mul_b = tmp_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// Region-two start value, truncated toward zero in quarter units
	always_comb begin
		r2_base = acc_q + prod_s1 + $signed({{(DW-SQ+2){1'b0}}, bsq_q[SQ-1:2]});
		if ((bsq_q[1:0] != 2'b00) && r2_base[DW-1]) begin
			r2_base = r2_base + DW'(1);
		end
	end

	// Drawing phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
		end else begin
			case (ctrl.op)
				OP_LOAD: begin
					if (load) begin
						phase_q <= PH_ONE;
					end
				end
				OP_SET_DONE: phase_q <= PH_DONE;
				OP_R2_INIT:  phase_q <= PH_TWO;
				OP_R2_XY: begin
					if (cur_y_q <= RAD'(1)) begin
						phase_q <= PH_DONE;
					end
				end
				default: phase_q <= phase_q;
			endcase
		end
	end

	// Execute the datapath action of the current step
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (load) begin
					ctr_x_q <= center_x;
					ctr_y_q <= center_y;
					a_q     <= radius_x;
					b_q     <= radius_y;
					color_q <= color;
					cur_x_q <= '0;
					cur_y_q <= radius_y;
					sx_q    <= '0;
				end
			end
			OP_SET_ASQ: asq_q <= prod_s1[SQ-1:0];
			OP_SET_BSQ: bsq_q <= prod_s1[SQ-1:0];
			OP_INIT: begin
				dec_q <= $signed({{(DW-SQ+2){1'b0}}, asq_q[SQ-1:2]}) + bsq_w - prod_s1;
				sy_q  <= {prod_s1[ST-2:0], 1'b0};
			end
			OP_R1_XY: begin
				cur_x_q <= cur_x_q + 1'b1;
				sx_q    <= sx_q + two_bsq;
				dneg_q  <= dec_q[DW-1];
				if (!dec_q[DW-1]) begin
					cur_y_q <= cur_y_q - 1'b1;
					sy_q    <= sy_q - two_asq;
				end
			end
			OP_R1_DEC: begin
				dec_q <= dec_q + bsq_w + sx_w - (dneg_q ? DW'(0) : sy_w);
			end
			OP_TMP_XX: begin
				tmp_q <= prod_s1[MW-1:0] + $signed({{(MW-RAD){1'b0}}, cur_x_q});
			end
			OP_TMP_YY: begin
				tmp_q <= prod_s1[MW-1:0] - $signed({{(MW-SQ){1'b0}}, bsq_q});
			end
			OP_ACC:     acc_q <= prod_s1;
			OP_R2_INIT: dec_q <= r2_base;
			OP_R2_XY: begin
				cur_y_q <= cur_y_q - 1'b1;
				sy_q    <= sy_q - two_asq;
				dpos_q  <= !dec_q[DW-1] && (dec_q != '0);
				if (dec_q[DW-1] || (dec_q == '0)) begin
					cur_x_q <= cur_x_q + 1'b1;
					sx_q    <= sx_q + two_bsq;
				end
			end
			OP_R2_DEC: begin
				dec_q <= dec_q + asq_w - sy_w + (dpos_q ? DW'(0) : sx_w);
			end
			default: begin
			end
		endcase
	end

	// Report flags to the sequencer
	always_comb begin
		stat.keep_r1 = (sx_q < sy_q);
		stat.y_zero  = (cur_y_q == '0);
		stat.ph_one  = (phase_q == PH_ONE);
		stat.ph_two  = (phase_q == PH_TWO);
	end

	// Form the four mirrored coordinates
	assign pt_right_x = $signed({2'b00, ctr_x_q} + {3'b000, cur_x_q});
	assign pt_left_x  = $signed({2'b00, ctr_x_q} - {3'b000, cur_x_q});
	assign pt_lower_y = $signed({2'b00, ctr_y_q} + {3'b000, cur_y_q});
	assign pt_upper_y = $signed({2'b00, ctr_y_q} - {3'b000, cur_y_q});
	assign pt_color   = color_q;
	assign pt_last    = (phase_q == PH_DONE);

endmodule

`default_nettype wire

// ----- sv/midpoint_ellipse_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse point generator run by a small microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): func=0 starts an ellipse from center,
//   radii and color; func=1 advances one point. Every transaction yields
//   exactly one result on the output channel (out_valid/out_stall) carrying
//   four mirrored coordinates, the color, valid_res and last.
//   Timing: the result register loads at the end of the item's microprogram
//   path, and the next item is taken in the cycle after, back in the idle
//   step. The path depends on the case: a step in either region, a step after
//   the final point, a start, a start ending at once, a step that ends region
//   one at y=0, a step entering region two, a start entering region two.
//   Setup terms go one by one through the single shared multiplier, one
//   product per cycle.
//   The output register lets the next item be accepted while a result waits.
//   While out_stall holds a pending result, the sequencer waits in its emit
//   step. Reset returns to the idle step with no ellipse in progress, so a
//   step item gives valid_res=0.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-2:0]        radius_x,
	input  logic [COORD_BITS-2:0]        radius_y,
	input  logic [23:0]                  color,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS+1:0] right_x,
	output logic signed [COORD_BITS+1:0] left_x,
	output logic signed [COORD_BITS+1:0] lower_y,
	output logic signed [COORD_BITS+1:0] upper_y,
	output logic [23:0]                  pixel_color,
	output logic                         valid_res,
	output logic                         last
);
	import mer_pkg::*;

	localparam int OW = COORD_BITS + 2;

	ctrl_t ctrl;
	stat_t stat;
	logic  idle;
	logic  accept;
	logic  out_busy;
	logic  emit_fire;

	logic signed [OW-1:0] pt_right_x, pt_left_x, pt_lower_y, pt_upper_y;
	logic [23:0]          pt_color;
	logic                 pt_last;

	logic                 res_valid_q;
	logic signed [OW-1:0] right_x_q, left_x_q, lower_y_q, upper_y_q;
	logic [23:0]          color_q;
	logic                 valid_res_q, last_q;

	// Input handshake
	assign in_stall  = !idle;
	assign accept    = in_valid && !in_stall;
	assign out_busy  = res_valid_q && out_stall;
	assign emit_fire = ((ctrl.op == OP_EMIT) || (ctrl.op == OP_EMIT_ZERO)) && !out_busy;

	mer_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.out_busy (out_busy),
		.stat     (stat),
		.ctrl     (ctrl),
		.idle     (idle)
	);

	mer_dpath #(
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.load       (accept && !func),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius_x   (radius_x),
		.radius_y   (radius_y),
		.color      (color),
		.stat       (stat),
		.pt_right_x (pt_right_x),
		.pt_left_x  (pt_left_x),
		.pt_lower_y (pt_lower_y),
		.pt_upper_y (pt_upper_y),
		.pt_color   (pt_color),
		.pt_last    (pt_last)
	);

	// Hold the result valid until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			if (ctrl.op == OP_EMIT) begin
				right_x_q   <= pt_right_x;
				left_x_q    <= pt_left_x;
				lower_y_q   <= pt_lower_y;
				upper_y_q   <= pt_upper_y;
				color_q     <= pt_color;
				valid_res_q <= 1'b1;
				last_q      <= pt_last;
			end else begin
				right_x_q   <= '0;
				left_x_q    <= '0;
				lower_y_q   <= '0;
				upper_y_q   <= '0;
				color_q     <= '0;
				valid_res_q <= 1'b0;
				last_q      <= 1'b0;
			end
		end
	end

	assign out_valid   = res_valid_q;
	assign right_x     = right_x_q;
	assign left_x      = left_x_q;
	assign lower_y     = lower_y_q;
	assign upper_y     = upper_y_q;
	assign pixel_color = color_q;
	assign valid_res   = valid_res_q;
	assign last        = last_q;

	// Sequencer leaves idle once it takes an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("sequencer still idle after accepting an item");

	// A new result only appears while an item is being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in progress");

	// Emit step waits while the result register is blocked
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((ctrl.op == OP_EMIT) && out_busy) |=> (ctrl.op == OP_EMIT))
		else $error("emit step left while result register was blocked");

endmodule

`default_nettype wire
